// ----- hw/rtl/sbmc_pkg.sv -----
`default_nettype none
package sbmc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int OUT_WIDTH   = 16;

   localparam logic [7:0] CHR_QMARK   = 8'h3F;
   localparam logic [7:0] CHR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHR_DASH    = 8'h2D;
   localparam logic [7:0] CHR_SLASH   = 8'h2F;
   localparam logic [7:0] CHR_STAR    = 8'h2A;
   localparam logic [7:0] CHR_NL      = 8'h0A;
   localparam logic [7:0] CHR_CR      = 8'h0D;
   localparam logic [7:0] CHR_TAB     = 8'h09;
   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_UNDER   = 8'h5F;

   localparam int KEYWORD_LEN = 7;
   localparam logic [2:0] KEYWORD_LAST = 3'(KEYWORD_LEN);

   typedef enum logic [3:0] {
      LX_NORMAL, LX_DASH, LX_SLASH, LX_SQ, LX_SQ_END, LX_DQ, LX_DQ_END,
      LX_LINE, LX_BLOCK, LX_BLOCK_STAR
   } lexer_mode_type;

   typedef enum logic [3:0] {
      PF_SKIP, PF_DASH, PF_SLASH, PF_LINE, PF_BLOCK, PF_BLOCK_STAR,
      PF_MATCH, PF_AFTER, PF_YES, PF_NO
   } prefix_mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] bind_count;
      logic                 prepare_found;
      logic [OUT_WIDTH-1:0] marker_total;
   } rsp_beat_type;

   function automatic logic [7:0] keyword_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0:    c = 8'h50;
         3'd1:    c = 8'h52;
         3'd2:    c = 8'h45;
         3'd3:    c = 8'h50;
         3'd4:    c = 8'h41;
         3'd5:    c = 8'h52;
         3'd6:    c = 8'h45;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) ? (b - 8'd32) : b;
   endfunction

   function automatic logic is_word_byte(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A) || b == CHR_UNDER;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sql_bind_marker_counter_core.sv -----
// The result beat is registered and appears in the cycle after the beat carrying last_byte is accepted.
// Throughput: one text byte per cycle; a last byte waits only while a
// previous result is held by rsp_stall.
// Reset: synchronous, active high; lexer in normal text, prefix checker
// skipping leading blanks, marker count zero, no result pending.
`default_nettype none
module sql_bind_marker_counter_core (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  sbmc_pkg::req_beat_type req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output sbmc_pkg::rsp_beat_type      rsp_data
);

   localparam int CW = sbmc_pkg::COUNT_WIDTH;
   localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

   sbmc_pkg::lexer_mode_type  lex_ff,  lex_in;
   sbmc_pkg::prefix_mode_type pfx_ff,  pfx_in;
   logic [2:0]                kpos_ff, kpos_in;
   logic [CW-1:0]             cnt_ff,  cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sbmc_pkg::rsp_beat_type    rsp_data_ff,  rsp_data_in;

   logic       accept;
   logic [7:0] b;
   logic       lex_norm_step;
   logic       match_step;
   logic [2:0] match_pos;
   logic [31:0] cnt_wide;
   logic [sbmc_pkg::OUT_WIDTH-1:0] total;
   logic       prep;

   assign req_stall = rsp_valid_ff && rsp_stall && req_data.last_byte;
   assign accept    = req_valid && !req_stall;
   assign b         = req_data.text_byte;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      lex_norm_step = 1'b0;
      lex_in        = lex_ff;
      unique case (lex_ff)
         sbmc_pkg::LX_DASH: begin
            if (b == sbmc_pkg::CHR_DASH) lex_in = sbmc_pkg::LX_LINE;
            else lex_norm_step = 1'b1;
         end
         sbmc_pkg::LX_SLASH: begin
            if (b == sbmc_pkg::CHR_STAR) lex_in = sbmc_pkg::LX_BLOCK;
            else lex_norm_step = 1'b1;
         end
         sbmc_pkg::LX_SQ: begin
            lex_in = (b == sbmc_pkg::CHR_SQUOTE) ? sbmc_pkg::LX_SQ_END : sbmc_pkg::LX_SQ;
         end
         sbmc_pkg::LX_SQ_END: begin
            if (b == sbmc_pkg::CHR_SQUOTE) lex_in = sbmc_pkg::LX_SQ;
            else lex_norm_step = 1'b1;
         end
         sbmc_pkg::LX_DQ: begin
            lex_in = (b == sbmc_pkg::CHR_DQUOTE) ? sbmc_pkg::LX_DQ_END : sbmc_pkg::LX_DQ;
         end
         sbmc_pkg::LX_DQ_END: begin
            if (b == sbmc_pkg::CHR_DQUOTE) lex_in = sbmc_pkg::LX_DQ;
            else lex_norm_step = 1'b1;
         end
         sbmc_pkg::LX_LINE: begin
            lex_in = (b == sbmc_pkg::CHR_NL) ? sbmc_pkg::LX_NORMAL : sbmc_pkg::LX_LINE;
         end
         sbmc_pkg::LX_BLOCK: begin
            lex_in = (b == sbmc_pkg::CHR_STAR) ? sbmc_pkg::LX_BLOCK_STAR : sbmc_pkg::LX_BLOCK;
         end
         sbmc_pkg::LX_BLOCK_STAR: begin
            priority if (b == sbmc_pkg::CHR_SLASH) lex_in = sbmc_pkg::LX_NORMAL;
            else if (b == sbmc_pkg::CHR_STAR) lex_in = sbmc_pkg::LX_BLOCK_STAR;
            else lex_in = sbmc_pkg::LX_BLOCK;
         end
         default: lex_norm_step = 1'b1;
      endcase

      cnt_in = cnt_ff;
      if (lex_norm_step) begin
         priority if (b == sbmc_pkg::CHR_SQUOTE) lex_in = sbmc_pkg::LX_SQ;
         else if (b == sbmc_pkg::CHR_DQUOTE) lex_in = sbmc_pkg::LX_DQ;
         else if (b == sbmc_pkg::CHR_DASH) lex_in = sbmc_pkg::LX_DASH;
         else if (b == sbmc_pkg::CHR_SLASH) lex_in = sbmc_pkg::LX_SLASH;
         else begin
            lex_in = sbmc_pkg::LX_NORMAL;
            if (b == sbmc_pkg::CHR_QMARK && cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      match_step = 1'b0;
      match_pos  = kpos_ff;
      pfx_in     = pfx_ff;
      kpos_in    = kpos_ff;
      unique case (pfx_ff)
         sbmc_pkg::PF_SKIP: begin
            priority if (b == sbmc_pkg::CHR_SPACE || b == sbmc_pkg::CHR_TAB ||
                         b == sbmc_pkg::CHR_CR || b == sbmc_pkg::CHR_NL)
               pfx_in = sbmc_pkg::PF_SKIP;
            else if (b == sbmc_pkg::CHR_DASH) pfx_in = sbmc_pkg::PF_DASH;
            else if (b == sbmc_pkg::CHR_SLASH) pfx_in = sbmc_pkg::PF_SLASH;
            else begin
               match_step = 1'b1;
               match_pos  = 3'd0;
               kpos_in    = 3'd0;
            end
         end
         sbmc_pkg::PF_DASH: begin
            pfx_in = (b == sbmc_pkg::CHR_DASH) ? sbmc_pkg::PF_LINE : sbmc_pkg::PF_NO;
         end
         sbmc_pkg::PF_SLASH: begin
            pfx_in = (b == sbmc_pkg::CHR_STAR) ? sbmc_pkg::PF_BLOCK : sbmc_pkg::PF_NO;
         end
         sbmc_pkg::PF_LINE: begin
            pfx_in = (b == sbmc_pkg::CHR_NL) ? sbmc_pkg::PF_SKIP : sbmc_pkg::PF_LINE;
         end
         sbmc_pkg::PF_BLOCK: begin
            pfx_in = (b == sbmc_pkg::CHR_STAR) ? sbmc_pkg::PF_BLOCK_STAR : sbmc_pkg::PF_BLOCK;
         end
         sbmc_pkg::PF_BLOCK_STAR: begin
            priority if (b == sbmc_pkg::CHR_SLASH) pfx_in = sbmc_pkg::PF_SKIP;
            else if (b == sbmc_pkg::CHR_STAR) pfx_in = sbmc_pkg::PF_BLOCK_STAR;
            else pfx_in = sbmc_pkg::PF_BLOCK;
         end
         sbmc_pkg::PF_MATCH: match_step = 1'b1;
         sbmc_pkg::PF_AFTER: begin
            pfx_in = sbmc_pkg::is_word_byte(b) ? sbmc_pkg::PF_NO : sbmc_pkg::PF_YES;
         end
         sbmc_pkg::PF_YES: pfx_in = sbmc_pkg::PF_YES;
         default: pfx_in = sbmc_pkg::PF_NO;
      endcase

      if (match_step) begin
         if (match_pos >= sbmc_pkg::KEYWORD_LAST ||
             sbmc_pkg::to_upper(b) != sbmc_pkg::keyword_char(match_pos)) begin
            pfx_in = sbmc_pkg::PF_NO;
         end else begin
            kpos_in = match_pos + 3'd1;
            pfx_in  = (kpos_in == sbmc_pkg::KEYWORD_LAST) ? sbmc_pkg::PF_AFTER
                                                          : sbmc_pkg::PF_MATCH;
         end
      end
   end

   always_comb begin
      cnt_wide = 32'(cnt_in);
      total    = (cnt_wide > 32'h0000_FFFF) ? 16'hFFFF : cnt_wide[15:0];
      prep     = (pfx_in == sbmc_pkg::PF_YES) || (pfx_in == sbmc_pkg::PF_AFTER);

      rsp_data_in.bind_count    = prep ? 16'd0 : total;
      rsp_data_in.prepare_found = prep;
      rsp_data_in.marker_total  = total;

      if (accept && req_data.last_byte) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff       <= sbmc_pkg::LX_NORMAL;
         pfx_ff       <= sbmc_pkg::PF_SKIP;
         kpos_ff      <= 3'd0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_data.last_byte) begin
               lex_ff  <= sbmc_pkg::LX_NORMAL;
               pfx_ff  <= sbmc_pkg::PF_SKIP;
               kpos_ff <= 3'd0;
               cnt_ff  <= '0;
            end else begin
               lex_ff  <= lex_in;
               pfx_ff  <= pfx_in;
               kpos_ff <= kpos_in;
               cnt_ff  <= cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.last_byte) rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_last_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=> rsp_valid_ff)
      else $error("last byte accepted without result beat");

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=> cnt_ff == '0 && lex_ff == sbmc_pkg::LX_NORMAL &&
                                       pfx_ff == sbmc_pkg::PF_SKIP && kpos_ff == 3'd0)
      else $error("statement state not cleared after last byte");

   a_prepare_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.prepare_found |-> rsp_data_ff.bind_count == 16'd0)
      else $error("bind count non-zero for prepare");

   a_plain_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.prepare_found |->
         rsp_data_ff.bind_count == rsp_data_ff.marker_total)
      else $error("bind count differs from marker total");

   a_kpos_range: assert property (@(posedge clock) disable iff (reset)
      kpos_ff <= sbmc_pkg::KEYWORD_LAST)
      else $error("keyword position out of range");
`endif

endmodule
`default_nettype wire
